// File: src/ffa_pkg.sv
// Shared types and constants of the first-fit heap allocator.
package ffa_pkg;

  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int MAX_BLOCKS_DEF   = 64;

  localparam logic [16:0] ALIGN_ADD   = 17'd15;
  localparam logic [16:0] ALIGN_MASK  = ~17'd15;
  localparam logic [17:0] SPLIT_SLACK = 18'd32;
  localparam logic [16:0] ARENA_RESET = 17'd65536;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic [15:0] off;
    logic [15:0] pay;
    logic        free;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic split;
  } match_t;

endpackage

// File: src/ffa_table.sv
// Block table memory: one write port, one registered read port.
module ffa_table #(
  parameter int DEPTH = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  ffa_pkg::entry_t        wdata,
  input  logic [AW-1:0]          raddr,
  output ffa_pkg::entry_t        rdata
);

  ffa_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/ffa_alu.sv
// Shared compare unit: tests one table entry against the current command.
module ffa_alu #(
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
  input  ffa_pkg::entry_t e,
  input  logic            cmd,
  input  logic [16:0]     size,
  input  logic [17:0]     split_th,
  input  logic [15:0]     faddr,
  output ffa_pkg::match_t m
);

  logic [16:0] pay_addr;

  always_comb begin
    pay_addr = {1'b0, e.off} + 17'(HEADER_BYTES);
    m.split  = {2'b00, e.pay} > split_th;
    if (cmd == ffa_pkg::CMD_ALLOC) begin
      m.hit = e.free && ({1'b0, e.pay} >= size);
    end else begin
      m.hit = pay_addr == {1'b0, faddr};
    end
  end

endmodule

// File: src/first_fit_heap_allocator.sv
// First-fit heap allocator: top level with the command sequencer.
// One command is worked at a time; s_tready is high only between commands, and
// an arena_size write is taken only then too, ahead of any waiting item.
// Each table entry visited takes a memory read state, then a check state; an
// allocate reads and checks entries up to the first fit, then for a split
// moves every later entry up by one (read, then write) before writing the two
// halves; a free finds its entry the same way and then runs a merge pass over
// all entries that rewrites the table. The block table memory has one write
// port and one registered read port. After reset and after each arena_size
// write, the S_INIT state rebuilds the table.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffa_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_size[15:0], free_address[31:16]
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // address[15:0]
  output logic        m_tuser,   // ok
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [11:0] {
    S_INIT    = 12'b000000000001,
    S_IDLE    = 12'b000000000010,
    S_RD      = 12'b000000000100,
    S_CHK     = 12'b000000001000,
    S_SH_RD   = 12'b000000010000,
    S_SH_WR   = 12'b000000100000,
    S_WR_A    = 12'b000001000000,
    S_WR_B    = 12'b000010000000,
    S_MG_RD   = 12'b000100000000,
    S_MG_CHK  = 12'b001000000000,
    S_MG_LAST = 12'b010000000000,
    S_DONE    = 12'b100000000000
  } state_t;

  state_t          state;
  logic [16:0]     arena;
  logic [CW-1:0]   count;
  logic            cmd;
  logic [16:0]     size;
  logic [17:0]     split_th;
  logic [15:0]     faddr;
  logic [CW-1:0]   j;
  logic [AW-1:0]   s;
  logic [AW-1:0]   k;
  logic [AW-1:0]   w;
  logic            have;
  ffa_pkg::entry_t cur;
  logic [15:0]     res_addr;
  logic            res_ok;

  logic            we;
  logic [AW-1:0]   waddr;
  ffa_pkg::entry_t wdata;
  logic [AW-1:0]   raddr;
  ffa_pkg::entry_t rdata;
  ffa_pkg::entry_t mg_e;
  ffa_pkg::match_t m;
  logic [16:0]     arena_clip;
  logic [16:0]     size_rnd;

  ffa_table #(.DEPTH(MAX_BLOCKS), .AW(AW)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  ffa_alu #(.HEADER_BYTES(HEADER_BYTES)) u_alu (
    .e       (rdata),
    .cmd     (cmd),
    .size    (size),
    .split_th(split_th),
    .faddr   (faddr),
    .m       (m)
  );

  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = state == S_IDLE;

  always_comb begin
    arena_clip = (arena > 17'(HEAP_BYTES)) ? 17'(HEAP_BYTES) : arena;
    size_rnd   = ({1'b0, s_tdata[15:0]} + ffa_pkg::ALIGN_ADD) & ffa_pkg::ALIGN_MASK;
    mg_e       = rdata;
    if (j[AW-1:0] == k) begin
      mg_e.free = 1'b1;
    end
  end

  // Memory ports follow the state.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state)
      S_INIT: begin
        we         = 1'b1;
        wdata.off  = '0;
        wdata.pay  = (arena_clip > 17'(HEADER_BYTES)) ?
                     16'(arena_clip - 17'(HEADER_BYTES)) : 16'd0;
        wdata.free = 1'b1;
      end
      S_RD:    raddr = j[AW-1:0];
      S_SH_RD: raddr = s;
      S_SH_WR: begin
        we    = 1'b1;
        waddr = s + AW'(1);
        wdata = rdata;
      end
      S_CHK: begin
        if (m.hit && cmd == ffa_pkg::CMD_ALLOC &&
            !(m.split && count < CW'(MAX_BLOCKS))) begin
          we         = 1'b1;
          waddr      = j[AW-1:0];
          wdata      = rdata;
          wdata.free = 1'b0;
        end
      end
      S_WR_A: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
        wdata = '{off: cur.off, pay: size[15:0], free: 1'b0};
      end
      S_WR_B: begin
        we         = 1'b1;
        waddr      = j[AW-1:0] + AW'(1);
        wdata.off  = 16'({1'b0, cur.off} + 17'(HEADER_BYTES) + size);
        wdata.pay  = 16'({1'b0, cur.pay} - size - 17'(HEADER_BYTES));
        wdata.free = 1'b1;
      end
      S_MG_RD: raddr = j[AW-1:0];
      S_MG_CHK: begin
        if (have && !(cur.free && mg_e.free)) begin
          we    = 1'b1;
          waddr = w;
          wdata = cur;
        end
      end
      S_MG_LAST: begin
        we    = 1'b1;
        waddr = w;
        wdata = cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      arena    <= ffa_pkg::ARENA_RESET;
      count    <= CW'(1);
      m_tvalid <= 1'b0;
    end else begin
      // drop the item once taken, unless a new result replaces it
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        arena <= cfg_data;
        state <= S_INIT;
      end else begin
        case (state)
          S_INIT: begin
            count <= CW'(1);
            state <= S_IDLE;
          end
          S_IDLE: begin
            if (s_tvalid) begin
              cmd      <= s_tuser;
              size     <= size_rnd;
              split_th <= {1'b0, size_rnd} + 18'(HEADER_BYTES) + ffa_pkg::SPLIT_SLACK;
              faddr    <= s_tdata[31:16];
              j        <= '0;
              state    <= S_RD;
            end
          end
          S_RD: begin
            if (j == count) begin
              res_addr <= '0;
              res_ok   <= 1'b0;
              state    <= S_DONE;
            end else begin
              state <= S_CHK;
            end
          end
          S_CHK: begin
            if (!m.hit) begin
              j     <= j + CW'(1);
              state <= S_RD;
            end else if (cmd == ffa_pkg::CMD_FREE) begin
              k     <= j[AW-1:0];
              j     <= '0;
              w     <= '0;
              have  <= 1'b0;
              state <= S_MG_RD;
            end else begin
              cur <= rdata;
              if (m.split && count < CW'(MAX_BLOCKS)) begin
                s <= AW'(count - CW'(1));
                if (count - CW'(1) > j) begin
                  state <= S_SH_RD;
                end else begin
                  state <= S_WR_A;
                end
              end else begin
                res_addr <= 16'({1'b0, rdata.off} + 17'(HEADER_BYTES));
                res_ok   <= 1'b1;
                state    <= S_DONE;
              end
            end
          end
          S_SH_RD: state <= S_SH_WR;
          S_SH_WR: begin
            if (CW'(s) == j + CW'(1)) begin
              state <= S_WR_A;
            end else begin
              s     <= s - AW'(1);
              state <= S_SH_RD;
            end
          end
          S_WR_A: state <= S_WR_B;
          S_WR_B: begin
            count    <= count + CW'(1);
            res_addr <= 16'({1'b0, cur.off} + 17'(HEADER_BYTES));
            res_ok   <= 1'b1;
            state    <= S_DONE;
          end
          S_MG_RD: begin
            if (j == count) begin
              state <= S_MG_LAST;
            end else begin
              state <= S_MG_CHK;
            end
          end
          S_MG_CHK: begin
            have <= 1'b1;
            if (!have) begin
              cur <= mg_e;
            end else if (cur.free && mg_e.free) begin
              cur.pay <= cur.pay + mg_e.pay + 16'(HEADER_BYTES);
            end else begin
              w   <= w + AW'(1);
              cur <= mg_e;
            end
            j     <= j + CW'(1);
            state <= S_MG_RD;
          end
          S_MG_LAST: begin
            count    <= CW'(w) + CW'(1);
            res_addr <= '0;
            res_ok   <= 1'b1;
            state    <= S_DONE;
          end
          S_DONE: begin
            // hold the result until the output register is free
            if (!m_tvalid || m_tready) begin
              m_tvalid <= 1'b1;
              m_tdata  <= res_addr;
              m_tuser  <= res_ok;
              state    <= S_IDLE;
            end
          end
          default: state <= S_INIT;
        endcase
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state != S_INIT |-> (count >= CW'(1) && count <= CW'(MAX_BLOCKS)))
    else $error("block count out of range");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !cfg_valid) |=> state == S_RD)
    else $error("accepted item did not start a search");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tdata == 16'd0)
    else $error("failed result carries an address");

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!m_tvalid || m_tready) && !cfg_valid) |=> m_tvalid)
    else $error("result not presented");

endmodule
